[design/sfcm_pkg.sv]
// Shared types and constants of the stick filter, calibration and mapping block.
`default_nettype none
package sfcm_pkg;

    localparam int SMP_W  = 12;
    localparam int CSUM_W = 22;
    localparam int OFF_W  = 20;
    localparam int CNT_W  = 10;
    localparam int CFG_W  = 12;
    localparam int IDX_W  = 3;
    localparam int NUM_W  = 30;
    localparam int DEN_W  = 10;
    localparam int DIV_STEPS = NUM_W / 2;
    localparam int DCNT_W = 4;
    localparam int PROD_W = 33;

    localparam logic [IDX_W-1:0] REG_WINDOW_LEN = 3'd0;
    localparam logic [IDX_W-1:0] REG_CAL_SAMPLES = 3'd1;
    localparam logic [IDX_W-1:0] REG_THR_CENTER = 3'd2;
    localparam logic [IDX_W-1:0] REG_THR_MIN = 3'd3;
    localparam logic [IDX_W-1:0] REG_THR_MAX = 3'd4;

    localparam logic [4:0]       RST_WINDOW_LEN = 5'd10;
    localparam logic [CNT_W-1:0] RST_CAL_SAMPLES = 10'd64;
    localparam logic [SMP_W-1:0] RST_THR_CENTER = 12'd1500;
    localparam logic [SMP_W-1:0] RST_THR_MIN = 12'd1001;
    localparam logic [SMP_W-1:0] RST_THR_MAX = 12'd1999;

    // 3.3 V / 4096 * 300, scaled by 2^20 with the average in 12.8 fixed point.
    localparam logic signed [PROD_W-1:0] MAP_GAIN = 33'sd990;
    localparam int MAP_SHIFT = 20;

    localparam logic [SMP_W-1:0] AVG_SAT = 12'hFFF;

    typedef struct packed {
        logic       accept;
        logic       update;
        logic       div_start;
        logic       div_off;
        logic       div_store;
        logic [1:0] ch;
        logic       mul;
        logic       clamp;
        logic       cal_acc;
        logic       cal_finish;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic func;
        logic cal_hit;
    } t_sts;

endpackage
`default_nettype wire

[design/stick_filter_calibrate_map.sv]
// Top level of the four-channel joystick filter, offset calibration and output mapper.
`default_nettype none
// Each request carries one 12-bit sample per stick channel. The block keeps a
// moving average of every channel over a ring of the last window_len samples
// (0 or anything above MAX_WINDOW selects MAX_WINDOW) and returns the truncated
// averages, saturated at 4095. Requests with func set also accumulate those
// averages; when cal_samples of them have been seen, the per-channel offsets
// become their mean in 12.8 fixed point and the block counts as calibrated.
// From the next request on, the yaw, height, pitch and roll outputs carry
// thr_center + trunc((avg - offset) * 990 / 4096), clamped first to thr_max and
// then to thr_min; before that they read 0 and mapped_valid is low. One request
// is in work at a time. All divisions share one radix-4 divider, and each
// division has its start and store steps around the divider's run. A normal
// request goes through accept, memory read, four average divisions, four
// mapping multiply and clamp steps, the calibration step and the output load,
// and a request that completes a calibration run adds four offset divisions.
// A finished result waits in an output register, so the next request can be
// accepted and worked on while it waits. Configuration is written through a
// plain write port; the user must write it only while the block is idle, which
// the block itself does not enforce.
module stick_filter_calibrate_map #(
    parameter int MAX_WINDOW = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_func,
    input  wire logic [sfcm_pkg::SMP_W-1:0]  i_raw_left_x,
    input  wire logic [sfcm_pkg::SMP_W-1:0]  i_raw_left_y,
    input  wire logic [sfcm_pkg::SMP_W-1:0]  i_raw_right_x,
    input  wire logic [sfcm_pkg::SMP_W-1:0]  i_raw_right_y,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [sfcm_pkg::SMP_W-1:0]       o_avg_left_x,
    output logic [sfcm_pkg::SMP_W-1:0]       o_avg_left_y,
    output logic [sfcm_pkg::SMP_W-1:0]       o_avg_right_x,
    output logic [sfcm_pkg::SMP_W-1:0]       o_avg_right_y,
    output logic [sfcm_pkg::SMP_W-1:0]       o_out_yaw,
    output logic [sfcm_pkg::SMP_W-1:0]       o_out_height,
    output logic [sfcm_pkg::SMP_W-1:0]       o_out_pitch,
    output logic [sfcm_pkg::SMP_W-1:0]       o_out_roll,
    output logic                             o_mapped_valid,
    output logic                             o_calibration_done,
    input  wire logic                        i_cfg_we,
    input  wire logic [sfcm_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sfcm_pkg::CFG_W-1:0]  i_cfg_data
);

    sfcm_pkg::t_cmd cmd;
    sfcm_pkg::t_sts sts;

    // Channel order everywhere inside: left x, left y, right x, right y.
    logic [sfcm_pkg::SMP_W-1:0] raw [4];
    logic [sfcm_pkg::SMP_W-1:0] avg [4];
    logic [sfcm_pkg::SMP_W-1:0] map [4];

    assign raw[0] = i_raw_left_x;
    assign raw[1] = i_raw_left_y;
    assign raw[2] = i_raw_right_x;
    assign raw[3] = i_raw_right_y;

    sfcm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    sfcm_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_func             (i_func),
        .i_raw              (raw),
        .o_avg              (avg),
        .o_map              (map),
        .o_mapped_valid     (o_mapped_valid),
        .o_calibration_done (o_calibration_done)
    );

    assign o_avg_left_x  = avg[0];
    assign o_avg_left_y  = avg[1];
    assign o_avg_right_x = avg[2];
    assign o_avg_right_y = avg[3];

    // Pitch follows the right vertical stick and roll the right horizontal one.
    assign o_out_yaw    = map[0];
    assign o_out_height = map[1];
    assign o_out_pitch  = map[3];
    assign o_out_roll   = map[2];

endmodule
`default_nettype wire

[design/sfcm_div.sv]
// Restoring unsigned divider that retires two quotient bits per cycle.
`default_nettype none
module sfcm_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [sfcm_pkg::NUM_W-1:0]   i_num,
    input  wire logic [sfcm_pkg::DEN_W-1:0]   i_den,
    output logic                              o_busy,
    output logic                              o_done,
    output logic [sfcm_pkg::NUM_W-1:0]        o_quo
);

    logic [sfcm_pkg::NUM_W-1:0]  r_q;
    logic [sfcm_pkg::DEN_W-1:0]  r_den;
    logic [sfcm_pkg::DEN_W-1:0]  r_rem;
    logic [sfcm_pkg::DCNT_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [sfcm_pkg::DEN_W:0]    rem1;
    logic [sfcm_pkg::DEN_W:0]    rem2;
    logic [sfcm_pkg::DEN_W-1:0]  mid;
    logic [sfcm_pkg::DEN_W-1:0]  n_rem;
    logic                        ge1;
    logic                        ge2;

    always_comb begin
        rem1 = {r_rem, r_q[sfcm_pkg::NUM_W-1]};
        ge1  = rem1 >= {1'b0, r_den};
        mid  = ge1 ? sfcm_pkg::DEN_W'(rem1 - {1'b0, r_den}) : rem1[sfcm_pkg::DEN_W-1:0];
        rem2 = {mid, r_q[sfcm_pkg::NUM_W-2]};
        ge2  = rem2 >= {1'b0, r_den};
        n_rem = ge2 ? sfcm_pkg::DEN_W'(rem2 - {1'b0, r_den}) : rem2[sfcm_pkg::DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == sfcm_pkg::DCNT_W'(sfcm_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[sfcm_pkg::NUM_W-3:0], ge1, ge2};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule
`default_nettype wire

[design/sfcm_dp.sv]
// Datapath: sample ring memory, running sums, calibration state, mapping and output register.
`default_nettype none
module sfcm_dp #(
    parameter int MAX_WINDOW = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sfcm_pkg::t_cmd              i_cmd,
    output sfcm_pkg::t_sts                   o_sts,
    input  wire logic                        i_cfg_we,
    input  wire logic [sfcm_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sfcm_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                        i_func,
    input  wire logic [sfcm_pkg::SMP_W-1:0]  i_raw [4],
    output logic [sfcm_pkg::SMP_W-1:0]       o_avg [4],
    output logic [sfcm_pkg::SMP_W-1:0]       o_map [4],
    output logic                             o_mapped_valid,
    output logic                             o_calibration_done
);

    localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int SW = sfcm_pkg::SMP_W + WW;
    localparam int RW = 4 * sfcm_pkg::SMP_W;

    // Configuration.
    logic [4:0]                    r_win_len;
    logic [sfcm_pkg::CNT_W-1:0]    r_cal_samples;
    logic [sfcm_pkg::SMP_W-1:0]    r_center;
    logic [sfcm_pkg::SMP_W-1:0]    r_min;
    logic [sfcm_pkg::SMP_W-1:0]    r_max;

    // Filter and calibration state.
    logic [RW-1:0]                 mem [MAX_WINDOW];
    logic                          r_vld [MAX_WINDOW];
    logic [RW-1:0]                 r_rd;
    logic                          r_rd_vld;
    logic [SW-1:0]                 r_sum [4];
    logic [WW-1:0]                 r_wpos;
    logic [sfcm_pkg::CNT_W-1:0]    r_cnt;
    logic [sfcm_pkg::CSUM_W-1:0]   r_csum [4];
    logic [sfcm_pkg::OFF_W-1:0]    r_off [4];
    logic                          r_calibrated;
    logic                          r_done;

    // Per request working registers.
    logic                          r_func;
    logic [sfcm_pkg::SMP_W-1:0]    r_raw [4];
    logic [WW-1:0]                 r_pos;
    logic [WW-1:0]                 r_win;
    logic                          r_vbefore;
    logic [sfcm_pkg::SMP_W-1:0]    r_avg [4];
    logic [sfcm_pkg::SMP_W-1:0]    r_map [4];
    logic signed [sfcm_pkg::PROD_W-1:0] r_prod;

    // Output register.
    logic [sfcm_pkg::SMP_W-1:0]    r_o_avg [4];
    logic [sfcm_pkg::SMP_W-1:0]    r_o_map [4];
    logic                          r_o_mv;
    logic                          r_o_done;

    logic [WW-1:0]                 win_c;
    logic [WW-1:0]                 pos_c;
    logic [sfcm_pkg::CNT_W-1:0]    cnt_inc;
    logic                          div_busy;
    logic                          div_done;
    logic [sfcm_pkg::NUM_W-1:0]    div_quo;
    logic [sfcm_pkg::NUM_W-1:0]    div_num;
    logic [sfcm_pkg::DEN_W-1:0]    div_den;
    logic [sfcm_pkg::SMP_W-1:0]    quo_sat;
    logic signed [21:0]            d_c;
    logic                          neg;
    logic [sfcm_pkg::PROD_W-1:0]   mag;
    logic [12:0]                   qm;
    logic signed [14:0]            qs;
    logic signed [14:0]            v;
    logic [sfcm_pkg::SMP_W-1:0]    map_c;

    always_comb begin
        if (r_win_len == 5'd0 || 32'(r_win_len) > MAX_WINDOW) begin
            win_c = WW'(MAX_WINDOW);
        end else begin
            win_c = WW'(r_win_len);
        end
        pos_c   = (r_wpos >= win_c) ? '0 : r_wpos;
        cnt_inc = r_cnt + 1'b1;

        if (i_cmd.div_off) begin
            div_num = {r_csum[i_cmd.ch], 8'b0};
            div_den = r_cnt;
        end else begin
            div_num = sfcm_pkg::NUM_W'(r_sum[i_cmd.ch]);
            div_den = sfcm_pkg::DEN_W'(r_win);
        end
        quo_sat = (div_quo[sfcm_pkg::NUM_W-1:sfcm_pkg::SMP_W] != '0) ? sfcm_pkg::AVG_SAT
                                                                   : div_quo[sfcm_pkg::SMP_W-1:0];

        d_c = $signed({2'b0, r_avg[i_cmd.ch], 8'b0}) - $signed({2'b0, r_off[i_cmd.ch]});

        // Truncation toward zero of the scaled product.
        neg = r_prod[sfcm_pkg::PROD_W-1];
        mag = neg ? sfcm_pkg::PROD_W'(-r_prod) : sfcm_pkg::PROD_W'(r_prod);
        qm  = mag[sfcm_pkg::MAP_SHIFT +: 13];
        qs  = neg ? (15'sd0 - $signed({2'b0, qm})) : $signed({2'b0, qm});
        v   = $signed({3'b0, r_center}) + qs;
        if (v > $signed({3'b0, r_max})) begin
            v = $signed({3'b0, r_max});
        end
        if (v < $signed({3'b0, r_min})) begin
            v = $signed({3'b0, r_min});
        end
        map_c = v[sfcm_pkg::SMP_W-1:0];
    end

    sfcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Ring memory: read at the accept edge, row written during the update.
    always_ff @(posedge i_clk) begin
        r_rd <= mem[pos_c[PW-1:0]];
        if (i_cmd.update) begin
            mem[r_pos[PW-1:0]] <= {r_raw[3], r_raw[2], r_raw[1], r_raw[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[pos_c[PW-1:0]];
            if (i_cmd.update) begin
                r_vld[r_pos[PW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len     <= sfcm_pkg::RST_WINDOW_LEN;
            r_cal_samples <= sfcm_pkg::RST_CAL_SAMPLES;
            r_center      <= sfcm_pkg::RST_THR_CENTER;
            r_min         <= sfcm_pkg::RST_THR_MIN;
            r_max         <= sfcm_pkg::RST_THR_MAX;
            r_wpos        <= '0;
            r_cnt         <= '0;
            r_calibrated  <= 1'b0;
            r_done        <= 1'b0;
            for (int c = 0; c < 4; c++) begin
                r_sum[c]  <= '0;
                r_csum[c] <= '0;
                r_off[c]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sfcm_pkg::REG_WINDOW_LEN:  r_win_len     <= i_cfg_data[4:0];
                    sfcm_pkg::REG_CAL_SAMPLES: r_cal_samples <= i_cfg_data[sfcm_pkg::CNT_W-1:0];
                    sfcm_pkg::REG_THR_CENTER:  r_center      <= i_cfg_data;
                    sfcm_pkg::REG_THR_MIN:     r_min         <= i_cfg_data;
                    sfcm_pkg::REG_THR_MAX:     r_max         <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_done <= 1'b0;
            end
            if (i_cmd.update) begin
                for (int c = 0; c < 4; c++) begin
                    r_sum[c] <= r_sum[c] + SW'(r_raw[c])
                                - (r_rd_vld ? SW'(r_rd[c*sfcm_pkg::SMP_W +: sfcm_pkg::SMP_W])
                                            : SW'(0));
                end
                r_wpos <= r_pos + 1'b1;
            end
            if (i_cmd.cal_acc) begin
                for (int c = 0; c < 4; c++) begin
                    r_csum[c] <= r_csum[c] + sfcm_pkg::CSUM_W'(r_avg[c]);
                end
                r_cnt <= cnt_inc;
            end
            if (i_cmd.div_store && i_cmd.div_off) begin
                r_off[i_cmd.ch]  <= div_quo[sfcm_pkg::OFF_W-1:0];
                r_csum[i_cmd.ch] <= '0;
            end
            if (i_cmd.cal_finish) begin
                r_cnt        <= '0;
                r_calibrated <= 1'b1;
                r_done       <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func    <= i_func;
            r_raw     <= i_raw;
            r_pos     <= pos_c;
            r_win     <= win_c;
            r_vbefore <= r_calibrated;
        end
        if (i_cmd.div_store && !i_cmd.div_off) begin
            r_avg[i_cmd.ch] <= quo_sat;
        end
        if (i_cmd.mul) begin
            r_prod <= sfcm_pkg::PROD_W'(d_c) * sfcm_pkg::MAP_GAIN;
        end
        if (i_cmd.clamp) begin
            r_map[i_cmd.ch] <= map_c;
        end
        if (i_cmd.out_load) begin
            r_o_avg  <= r_avg;
            for (int c = 0; c < 4; c++) begin
                r_o_map[c] <= r_vbefore ? r_map[c] : '0;
            end
            r_o_mv   <= r_vbefore;
            r_o_done <= r_done;
        end
    end

    assign o_sts.div_busy = div_busy;
    assign o_sts.div_done = div_done;
    assign o_sts.func     = r_func;
    assign o_sts.cal_hit  = (cnt_inc >= r_cal_samples);

    assign o_avg              = r_o_avg;
    assign o_map              = r_o_map;
    assign o_mapped_valid     = r_o_mv;
    assign o_calibration_done = r_o_done;

endmodule
`default_nettype wire

[design/sfcm_ctrl.sv]
// Controller state machine that sequences one request through the datapath.
`default_nettype none
module sfcm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  wire logic           i_stall,
    output sfcm_pkg::t_cmd      o_cmd,
    input  wire sfcm_pkg::t_sts i_sts
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_DAVG  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_CLAMP = 4'd4;
    localparam logic [3:0] S_CAL   = 4'd5;
    localparam logic [3:0] S_DOFF  = 4'd6;
    localparam logic [3:0] S_WB    = 4'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [1:0] r_ch;
    logic [1:0] n_ch;
    logic       r_wait;
    logic       n_wait;
    logic       r_ovalid;
    logic       n_ovalid;
    sfcm_pkg::t_cmd cmd;

    always_comb begin
        cmd      = '0;
        n_state  = r_state;
        n_ch     = r_ch;
        n_wait   = r_wait;
        n_ovalid = r_ovalid && i_stall;
        cmd.ch   = r_ch;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                cmd.update = 1'b1;
                n_ch       = 2'd0;
                n_state    = S_DAVG;
            end
            S_DAVG, S_DOFF: begin
                cmd.div_off = (r_state == S_DOFF);
                if (!r_wait) begin
                    cmd.div_start = 1'b1;
                    n_wait        = 1'b1;
                end else if (i_sts.div_done) begin
                    cmd.div_store = 1'b1;
                    n_wait        = 1'b0;
                    n_ch          = r_ch + 1'b1;
                    if (r_ch == 2'd3) begin
                        if (r_state == S_DOFF) begin
                            cmd.cal_finish = 1'b1;
                            n_state        = S_WB;
                        end else begin
                            n_state = S_MUL;
                        end
                    end
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                cmd.clamp = 1'b1;
                n_ch      = r_ch + 1'b1;
                n_state   = (r_ch == 2'd3) ? S_CAL : S_MUL;
            end
            S_CAL: begin
                n_ch = 2'd0;
                if (i_sts.func) begin
                    cmd.cal_acc = 1'b1;
                    n_state     = i_sts.cal_hit ? S_DOFF : S_WB;
                end else begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (!r_ovalid || !i_stall) begin
                    cmd.out_load = 1'b1;
                    n_ovalid     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ch     <= 2'd0;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ch     <= n_ch;
            r_wait   <= n_wait;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_cmd   = cmd;

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input not stalled while a request is in work");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_READ))
        else $error("accepted request did not start the memory read");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !i_sts.div_busy)
        else $error("divider started while busy");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_ovalid || !i_stall))
        else $error("output register overwritten before it was taken");

endmodule
`default_nettype wire
